// ----- rtl/ecgre_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants of the relative energy ecg filter
// no dependencies; used by ecgre_div, ecgre_dp, ecgre_ctrl and the top level
package ecgre_pkg;

	localparam int LONG_LEN_DEF   = 256;
	localparam int SHORT_HALF_DEF = 16;
	localparam int SAMPLE_W       = 16;
	localparam int ENERGY_W       = 32;
	localparam int DIV_W          = 32;
	localparam logic [15:0] SCALE_RESET = 16'd10000;

	typedef enum logic [2:0] {
		ACC_NONE = 3'd0,
		ACC_FILL = 3'd1,
		ACC_NEW  = 3'd2,
		ACC_OLD  = 3'd3,
		ACC_HEAD = 3'd4,
		ACC_TAIL = 3'd5
	} acc_op_t;

	typedef enum logic [1:0] {
		RD_OLD  = 2'd0,
		RD_HEAD = 2'd1,
		RD_TAIL = 2'd2,
		RD_CTR  = 2'd3
	} rd_sel_t;

	typedef enum logic [1:0] {
		DS_LONG_SC  = 2'd0,
		DS_SHORT_Q  = 2'd1,
		DS_MULSC    = 2'd2,
		DS_PROD_SC  = 2'd3
	} div_src_t;

	typedef struct packed {
		logic     accept;
		logic     sq_en;
		logic     sq_from_rd;
		acc_op_t  acc_op;
		logic     rd_en;
		rd_sel_t  rd_sel;
		logic     div_start;
		div_src_t div_src;
		logic     coef_from_div;
		logic     coef_direct;
		logic     prod_en;
		logic     out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic filling;
		logic long_gt_sc;
		logic long_zero;
		logic div_done;
		logic div_busy;
		logic out_free;
	} dp_stat_t;

endpackage

// ----- rtl/ecgre_if.sv -----
`timescale 1ns / 1ps
// valid/ready channel interfaces: sample input, result output, scale write
// no dependencies
interface ecgre_sample_if;
	logic valid;
	logic ready;
	logic signed [15:0] ecg_sample;
	modport source(output valid, output ecg_sample, input ready);
	modport sink(input valid, input ecg_sample, output ready);
endinterface

interface ecgre_result_if;
	logic valid;
	logic ready;
	logic signed [15:0] weighted_sample;
	logic [15:0] coefficient;
	logic primed;
	modport source(output valid, output weighted_sample, output coefficient, output primed,
		input ready);
	modport sink(input valid, input weighted_sample, input coefficient, input primed,
		output ready);
endinterface

interface ecgre_cfg_if;
	logic valid;
	logic ready;
	logic [15:0] scale;
	modport source(output valid, output scale, input ready);
	modport sink(input valid, input scale, output ready);
endinterface

// ----- rtl/ecgre_div.sv -----
`timescale 1ns / 1ps
// unsigned 32-bit restoring divider, one quotient bit per cycle
// depends on ecgre_pkg
module ecgre_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        busy,
	output logic        done,
	output logic [31:0] quotient
);
	import ecgre_pkg::*;

	localparam int CNT_W = $clog2(DIV_W);

	logic [DIV_W-1:0] rem_q, quo_q, dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;
	logic [DIV_W:0]   partial, partial_sub;
	logic             ge;

	assign partial     = {rem_q, quo_q[DIV_W-1]};
	assign ge          = partial >= {1'b0, dvs_q};
	assign partial_sub = partial - {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? partial_sub[DIV_W-1:0] : partial[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(DIV_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- rtl/ecgre_dp.sv -----
`timescale 1ns / 1ps
// datapath: sample ring, energy sums, squarer, coefficient and output registers
// depends on ecgre_pkg and ecgre_div
module ecgre_dp #(
	parameter int LONG_LEN   = ecgre_pkg::LONG_LEN_DEF,
	parameter int SHORT_HALF = ecgre_pkg::SHORT_HALF_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ecgre_pkg::dp_cmd_t  cmd,
	output ecgre_pkg::dp_stat_t stat,
	input  logic [15:0]         scale,
	input  logic signed [15:0]  in_sample,
	input  logic                out_ready,
	output logic                out_valid,
	output logic signed [15:0]  out_weighted,
	output logic [15:0]         out_coef,
	output logic                out_primed
);
	import ecgre_pkg::*;

	localparam int DEPTH    = LONG_LEN + 1;
	localparam int IDX_W    = $clog2(DEPTH);
	localparam int WIN_LO   = LONG_LEN / 2 - SHORT_HALF;
	localparam int WIN_HI   = LONG_LEN / 2 + SHORT_HALF;
	localparam int HEAD0    = (LONG_LEN / 2 + SHORT_HALF + 1) % DEPTH;
	localparam int TAIL0    = ((WIN_LO % DEPTH) + DEPTH) % DEPTH;

	function automatic logic [IDX_W-1:0] bump(input logic [IDX_W-1:0] i);
		return (i == IDX_W'(LONG_LEN)) ? '0 : i + 1'b1;
	endfunction

	logic signed [SAMPLE_W-1:0] ring_mem [DEPTH];

	logic [IDX_W-1:0]           wi_q, old_q, head_q, tail_q, ctr_q, rd_addr;
	logic                       filling_q;
	logic [ENERGY_W-1:0]        long_q, short_q, sq_q;
	logic signed [SAMPLE_W-1:0] samp_q, rd_q, sq_src;
	logic signed [31:0]         sq_full;
	logic [15:0]                coef_q, sc;
	logic signed [32:0]         prod_q;
	logic [47:0]                mulsc;
	logic [31:0]                prod_mag, div_a, div_b, div_quo;
	logic                       win, div_busy, div_done;
	logic                       out_valid_q, primed_q;
	logic signed [15:0]         weighted_q;
	logic [15:0]                out_coef_q;

	assign sc = (scale == 16'd0) ? 16'd1 : scale;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ring_mem[wi_q] <= in_sample;
		end
	end

	always_comb begin
		case (cmd.rd_sel)
			RD_OLD:  rd_addr = old_q;
			RD_HEAD: rd_addr = head_q;
			RD_TAIL: rd_addr = tail_q;
			RD_CTR:  rd_addr = ctr_q;
			default: rd_addr = ctr_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_q <= ring_mem[rd_addr];
		end
		if (cmd.accept) begin
			samp_q <= in_sample;
		end
	end

	// squarer shared by the new sample and ring reads
	assign sq_src  = cmd.sq_from_rd ? rd_q : samp_q;
	assign sq_full = sq_src * sq_src;

	always_ff @(posedge clk) begin
		if (cmd.sq_en) begin
			sq_q <= sq_full;
		end
	end

	assign win = (int'(wi_q) >= WIN_LO) && (int'(wi_q) <= WIN_HI);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_q  <= '0;
			short_q <= '0;
		end else begin
			case (cmd.acc_op)
				ACC_FILL: begin
					long_q <= long_q + sq_q;
					if (win) begin
						short_q <= short_q + sq_q;
					end
				end
				ACC_NEW:  long_q  <= long_q + sq_q;
				ACC_OLD:  long_q  <= long_q - sq_q;
				ACC_HEAD: short_q <= short_q + sq_q;
				ACC_TAIL: short_q <= short_q - sq_q;
				default: ;
			endcase
		end
	end

	assign mulsc    = short_q * sc;
	assign prod_mag = prod_q[32] ? 32'(-prod_q) : prod_q[31:0];

	always_comb begin
		case (cmd.div_src)
			DS_LONG_SC: begin div_a = long_q;      div_b = {16'd0, sc}; end
			DS_SHORT_Q: begin div_a = short_q;     div_b = div_quo;     end
			DS_MULSC:   begin div_a = mulsc[31:0]; div_b = long_q;      end
			DS_PROD_SC: begin div_a = prod_mag;    div_b = {16'd0, sc}; end
			default:    begin div_a = prod_mag;    div_b = {16'd0, sc}; end
		endcase
	end

	ecgre_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.coef_from_div) begin
			coef_q <= div_quo[15:0];
		end else if (cmd.coef_direct) begin
			coef_q <= mulsc[15:0];
		end
		if (cmd.prod_en) begin
			prod_q <= $signed({1'b0, coef_q}) * rd_q;
		end
	end

	// ring pointers and fill flag move once per item, when its result is loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wi_q      <= '0;
			old_q     <= '0;
			head_q    <= '0;
			tail_q    <= '0;
			ctr_q     <= IDX_W'(LONG_LEN / 2);
			filling_q <= 1'b1;
		end else if (cmd.out_load) begin
			wi_q <= bump(wi_q);
			if (filling_q) begin
				if (wi_q == IDX_W'(LONG_LEN - 1)) begin
					old_q     <= '0;
					head_q    <= IDX_W'(HEAD0);
					tail_q    <= IDX_W'(TAIL0);
					filling_q <= 1'b0;
					ctr_q     <= bump(ctr_q);
				end
			end else begin
				old_q  <= bump(old_q);
				head_q <= bump(head_q);
				tail_q <= bump(tail_q);
				ctr_q  <= bump(ctr_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (filling_q) begin
				weighted_q <= '0;
				out_coef_q <= '0;
				primed_q   <= 1'b0;
			end else begin
				weighted_q <= prod_q[32] ? -div_quo[15:0] : div_quo[15:0];
				out_coef_q <= coef_q;
				primed_q   <= 1'b1;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign out_weighted = weighted_q;
	assign out_coef     = out_coef_q;
	assign out_primed   = primed_q;

	always_comb begin
		stat.filling    = filling_q;
		stat.long_gt_sc = long_q > {16'd0, sc};
		stat.long_zero  = (long_q == '0);
		stat.div_done   = div_done;
		stat.div_busy   = div_busy;
		stat.out_free   = !out_valid_q || out_ready;
	end

endmodule

// ----- rtl/ecgre_ctrl.sv -----
`timescale 1ns / 1ps
// controller: sequences ring reads, energy updates, divisions and result load
// depends on ecgre_pkg
module ecgre_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ecgre_pkg::dp_stat_t stat,
	output ecgre_pkg::dp_cmd_t  cmd
);
	import ecgre_pkg::*;

	typedef enum logic [13:0] {
		ST_IDLE    = 14'h0001,
		ST_NEW_SQ  = 14'h0002,
		ST_NEW_ACC = 14'h0004,
		ST_RD      = 14'h0008,
		ST_RD_SQ   = 14'h0010,
		ST_RD_ACC  = 14'h0020,
		ST_CTR_RD  = 14'h0040,
		ST_COEF    = 14'h0080,
		ST_DIV_A   = 14'h0100,
		ST_DIV_B   = 14'h0200,
		ST_PROD    = 14'h0400,
		ST_QSTART  = 14'h0800,
		ST_DIV_C   = 14'h1000,
		ST_OUT     = 14'h2000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] k_q, k_d;
	rd_sel_t    k_sel;
	acc_op_t    k_acc;

	always_comb begin
		case (k_q)
			2'd0:    begin k_sel = RD_OLD;  k_acc = ACC_OLD;  end
			2'd1:    begin k_sel = RD_HEAD; k_acc = ACC_HEAD; end
			2'd2:    begin k_sel = RD_TAIL; k_acc = ACC_TAIL; end
			default: begin k_sel = RD_TAIL; k_acc = ACC_TAIL; end
		endcase
	end

	always_comb begin
		state_d  = state_q;
		k_d      = k_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.acc_op  = ACC_NONE;
		cmd.rd_sel  = RD_CTR;
		cmd.div_src = DS_LONG_SC;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid) begin
					state_d = ST_NEW_SQ;
				end
			end
			ST_NEW_SQ: begin
				cmd.sq_en = 1'b1;
				state_d   = ST_NEW_ACC;
			end
			ST_NEW_ACC: begin
				k_d = 2'd0;
				if (stat.filling) begin
					cmd.acc_op = ACC_FILL;
					state_d    = ST_OUT;
				end else begin
					cmd.acc_op = ACC_NEW;
					state_d    = ST_RD;
				end
			end
			ST_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = k_sel;
				state_d    = ST_RD_SQ;
			end
			ST_RD_SQ: begin
				cmd.sq_en      = 1'b1;
				cmd.sq_from_rd = 1'b1;
				state_d        = ST_RD_ACC;
			end
			ST_RD_ACC: begin
				cmd.acc_op = k_acc;
				if (k_q == 2'd2) begin
					state_d = ST_CTR_RD;
				end else begin
					k_d     = k_q + 2'd1;
					state_d = ST_RD;
				end
			end
			ST_CTR_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_CTR;
				state_d    = ST_COEF;
			end
			ST_COEF: begin
				if (stat.long_gt_sc) begin
					cmd.div_start = 1'b1;
					cmd.div_src   = DS_LONG_SC;
					state_d       = ST_DIV_A;
				end else if (!stat.long_zero) begin
					cmd.div_start = 1'b1;
					cmd.div_src   = DS_MULSC;
					state_d       = ST_DIV_B;
				end else begin
					cmd.coef_direct = 1'b1;
					state_d         = ST_PROD;
				end
			end
			ST_DIV_A: begin
				if (stat.div_done) begin
					cmd.div_start = 1'b1;
					cmd.div_src   = DS_SHORT_Q;
					state_d       = ST_DIV_B;
				end
			end
			ST_DIV_B: begin
				if (stat.div_done) begin
					cmd.coef_from_div = 1'b1;
					state_d           = ST_PROD;
				end
			end
			ST_PROD: begin
				cmd.prod_en = 1'b1;
				state_d     = ST_QSTART;
			end
			ST_QSTART: begin
				cmd.div_start = 1'b1;
				cmd.div_src   = DS_PROD_SC;
				state_d       = ST_DIV_C;
			end
			ST_DIV_C: begin
				if (stat.div_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= 2'd0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
		end
	end

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> stat.out_free)
		else $error("result loaded over an untaken result");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !stat.div_busy)
		else $error("divider restarted while busy");

	a_fill_short: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NEW_ACC && stat.filling) |=> state_q == ST_OUT)
		else $error("fill item took the primed path");

	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RD |-> k_q != 2'd3)
		else $error("ring operand counter out of range");

endmodule

// ----- rtl/ecg_relative_energy_filter.sv -----
`timescale 1ns / 1ps
// top level of the relative energy ecg filter: scale register, controller, datapath
// depends on ecgre_pkg, ecgre_if, ecgre_ctrl, ecgre_dp
//
// One signed 16-bit ECG sample per transaction on samples, one result per
// sample on results. While the first LONG_LEN samples arrive the block only
// accumulates energy and returns zeros with primed low. After that each
// sample updates the long and short sliding energies (three more ring reads,
// squared through one 16x16 multiplier) and forms the coefficient and
// weighted sample with one shared serial divider that retires one quotient
// bit per cycle. A primed sample uses three divisions when the long energy
// exceeds scale, two when it is nonzero but not above scale and one when it
// is zero. Any wait for results to take the previous result lengthens the
// processing of a sample. The next sample is accepted while the previous
// result still waits on results.
// The user must write scale through cfg only while the block is idle; the
// block does not enforce this. A zero scale acts as one. The sample ring
// needs no clearing after reset.
module ecg_relative_energy_filter #(
	parameter int LONG_LEN   = ecgre_pkg::LONG_LEN_DEF,
	parameter int SHORT_HALF = ecgre_pkg::SHORT_HALF_DEF
) (
	input logic           clk,
	input logic           arst_n,
	ecgre_sample_if.sink  samples,
	ecgre_result_if.source results,
	ecgre_cfg_if.sink     cfg
);
	import ecgre_pkg::*;

	dp_cmd_t     cmd;
	dp_stat_t    stat;
	logic [15:0] scale_q;

	// scale register, always ready for a write transaction
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
		end else if (cfg.valid) begin
			scale_q <= cfg.scale;
		end
	end

	// sequencer: one sample at a time through ring reads, squares and divisions
	ecgre_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_ready (samples.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// ring memory, energies, divider and the output register
	ecgre_dp #(
		.LONG_LEN   (LONG_LEN),
		.SHORT_HALF (SHORT_HALF)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.scale        (scale_q),
		.in_sample    (samples.ecg_sample),
		.out_ready    (results.ready),
		.out_valid    (results.valid),
		.out_weighted (results.weighted_sample),
		.out_coef     (results.coefficient),
		.out_primed   (results.primed)
	);

endmodule
